// ----- src/s3sq_pkg.sv -----
// Shared constants, control word types and the microcode program for the lattice point counter.
package s3sq_pkg;

    // Width of the distance input and the derived datapath widths.
    localparam int DIST_BITS  = 16;
    localparam int HALF_BITS  = (DIST_BITS + 1) / 2;
    localparam int ROOT_BITS  = HALF_BITS + 2;
    localparam int SQ_BITS    = 2 * HALF_BITS + 2;
    localparam int COUNT_BITS = 18;
    localparam int WEIGHT_BITS = 6;
    localparam int PC_BITS    = 4;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // Variant counts for one ordered triple x >= y >= z >= 0.
    localparam logic [WEIGHT_BITS-1:0] W_AXIS   = WEIGHT_BITS'(6);
    localparam logic [WEIGHT_BITS-1:0] W_DIAG2  = WEIGHT_BITS'(3 * 4);
    localparam logic [WEIGHT_BITS-1:0] W_PLANE  = WEIGHT_BITS'(3 * 4 * 2);
    localparam logic [WEIGHT_BITS-1:0] W_DIAG3  = WEIGHT_BITS'(2 * 2 * 2);
    localparam logic [WEIGHT_BITS-1:0] W_PAIR   = WEIGHT_BITS'(3 * 2 * 4);
    localparam logic [WEIGHT_BITS-1:0] W_GENERAL = WEIGHT_BITS'(6 * 2 * 2 * 2);

    // Datapath operations, one per control word.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_INIT,
        OP_DEC_Z0,
        OP_LOAD_Y0,
        OP_LOAD_R,
        OP_DEC_Z,
        OP_ACCUM,
        OP_INC_Y,
        OP_INC_X,
        OP_SET_ONE,
        OP_FINISH
    } t_op;

    // Jump conditions.
    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_M_ZERO,
        C_XSQ_GT_M,
        C_Z0SQ_GT_REST,
        C_Y_DONE,
        C_ZSQ_GT_R
    } t_cond;

    typedef logic [PC_BITS-1:0] t_pc;

    // One control word: operation, jump condition, jump target, and whether
    // the operation is gated by the condition.
    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_pc   target;
        logic  op_on_jump;
    } t_uword;

    // Step addresses of the program.
    localparam t_pc S_START = t_pc'(0);
    localparam t_pc S_XCHK  = t_pc'(1);
    localparam t_pc S_ZA    = t_pc'(2);
    localparam t_pc S_Y0    = t_pc'(3);
    localparam t_pc S_YC    = t_pc'(4);
    localparam t_pc S_YR    = t_pc'(5);
    localparam t_pc S_ZB    = t_pc'(6);
    localparam t_pc S_ACC   = t_pc'(7);
    localparam t_pc S_YN    = t_pc'(8);
    localparam t_pc S_XN    = t_pc'(9);
    localparam t_pc S_ONE   = t_pc'(10);
    localparam t_pc S_FIN   = t_pc'(11);

    // Program ROM. Unused addresses finish the request.
    function automatic t_uword ucode(input t_pc pc);
        t_uword w;
        begin
            unique case (pc)
                S_START: w = '{OP_INIT,    C_M_ZERO,       S_ONE,   1'b0};
                S_XCHK:  w = '{OP_NONE,    C_XSQ_GT_M,     S_FIN,   1'b0};
                S_ZA:    w = '{OP_DEC_Z0,  C_Z0SQ_GT_REST, S_ZA,    1'b1};
                S_Y0:    w = '{OP_LOAD_Y0, C_NEVER,        S_START, 1'b0};
                S_YC:    w = '{OP_NONE,    C_Y_DONE,       S_XN,    1'b0};
                S_YR:    w = '{OP_LOAD_R,  C_NEVER,        S_START, 1'b0};
                S_ZB:    w = '{OP_DEC_Z,   C_ZSQ_GT_R,     S_ZB,    1'b1};
                S_ACC:   w = '{OP_ACCUM,   C_NEVER,        S_START, 1'b0};
                S_YN:    w = '{OP_INC_Y,   C_ALWAYS,       S_YC,    1'b0};
                S_XN:    w = '{OP_INC_X,   C_ALWAYS,       S_XCHK,  1'b0};
                S_ONE:   w = '{OP_SET_ONE, C_ALWAYS,       S_FIN,   1'b0};
                default: w = '{OP_FINISH,  C_NEVER,        S_START, 1'b0};
            endcase
            return w;
        end
    endfunction

    // Number of sign and order variants of a triple x >= y >= z >= 0.
    function automatic logic [WEIGHT_BITS-1:0] variant_weight(
        input logic [ROOT_BITS-1:0] x,
        input logic [ROOT_BITS-1:0] y,
        input logic [ROOT_BITS-1:0] z
    );
        logic [WEIGHT_BITS-1:0] w;
        begin
            if (y == '0) begin
                w = W_AXIS;
            end else if (z == '0) begin
                w = (x == y) ? W_DIAG2 : W_PLANE;
            end else if (x == y && y == z) begin
                w = W_DIAG3;
            end else if (x == y || y == z) begin
                w = W_PAIR;
            end else begin
                w = W_GENERAL;
            end
            return w;
        end
    endfunction

endpackage

// ----- src/sum_of_three_squares_count.sv -----
// Top level: microcoded counter of cubic lattice points at a given squared distance.
//
// Usage: drive i_squared_distance and raise start while busy is low; the request
// is taken at that clock edge and busy rises on the next cycle. When the count is
// ready, o_done is high for exactly one cycle with o_point_count valid in that
// cycle, and busy falls at the same edge, so a new request may start right away.
// The receiver cannot stall the result; it must take it in the cycle it appears.
// The counter walks ordered triples x >= y >= z >= 0 with x*x+y*y+z*z = m, using
// incrementally updated squares and a z pointer that only walks downward.
// Each (x, y) pair with y <= x runs the steps YC, YR, ZB, ACC and YN, repeating
// ZB for each z decrement; each x value adds XCHK, ZA, Y0, the closing YC and XN,
// and the row root search walks z down from 256 once per request. The single
// program counter steps one control word per cycle.
// One request is in flight at a time. The count saturates at 262143.
// Reset (i_rst_n low, synchronous) clears busy and o_done and drops any request
// in flight; none is invented or accepted while reset is low.
module sum_of_three_squares_count
    import s3sq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [DIST_BITS-1:0]  i_squared_distance,
    output logic                  o_done,
    output logic [COUNT_BITS-1:0] o_point_count
);

    // Control state.
    logic r_busy, n_busy;
    logic r_done, n_done;
    t_pc  r_pc, n_pc;

    // Datapath registers.
    logic [DIST_BITS-1:0]  r_m, n_m;
    logic [ROOT_BITS-1:0]  r_x, n_x, r_y, n_y, r_z, n_z, r_z0, n_z0;
    logic [SQ_BITS-1:0]    r_xsq, n_xsq, r_ysq, n_ysq, r_zsq, n_zsq, r_z0sq, n_z0sq;
    logic [SQ_BITS-1:0]    r_rest, n_rest, r_r, n_r;
    logic [COUNT_BITS-1:0] r_total, n_total, r_count, n_count;

    t_uword               cw;
    logic                 take;
    logic                 op_en;
    logic                 hit;
    logic [SQ_BITS-1:0]   m_wide;
    logic [COUNT_BITS:0]  acc_sum;

    assign busy          = r_busy;
    assign o_done        = r_done;
    assign o_point_count = r_count;

    assign m_wide = SQ_BITS'(r_m);
    assign cw     = ucode(r_pc);

    // Jump condition evaluation.
    always_comb begin
        unique case (cw.cond)
            C_NEVER:        take = 1'b0;
            C_ALWAYS:       take = 1'b1;
            C_M_ZERO:       take = (r_m == '0);
            C_XSQ_GT_M:     take = (r_xsq > m_wide);
            C_Z0SQ_GT_REST: take = (r_z0sq > r_rest);
            C_Y_DONE:       take = (r_y > r_x) || (r_ysq > r_rest);
            C_ZSQ_GT_R:     take = (r_zsq > r_r);
            default:        take = 1'b0;
        endcase
    end

    assign op_en   = r_busy && (!cw.op_on_jump || take);
    assign hit     = (r_zsq == r_r) && (r_z <= r_y);
    assign acc_sum = {1'b0, r_total} + (COUNT_BITS + 1)'(variant_weight(r_x, r_y, r_z));

    // Sequencer and datapath next-value logic.
    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_pc    = r_pc;
        n_m     = r_m;
        n_x     = r_x;
        n_y     = r_y;
        n_z     = r_z;
        n_z0    = r_z0;
        n_xsq   = r_xsq;
        n_ysq   = r_ysq;
        n_zsq   = r_zsq;
        n_z0sq  = r_z0sq;
        n_rest  = r_rest;
        n_r     = r_r;
        n_total = r_total;
        n_count = r_count;

        if (!r_busy) begin
            // Idle: take a new request.
            if (start) begin
                n_busy = 1'b1;
                n_pc   = S_START;
                n_m    = i_squared_distance;
            end
        end else begin
            n_pc = take ? cw.target : r_pc + t_pc'(1);
        end

        if (op_en) begin
            unique case (cw.op)
                OP_NONE: begin
                end
                OP_INIT: begin
                    n_total = '0;
                    n_x     = '0;
                    n_xsq   = '0;
                    n_rest  = m_wide;
                    n_z0    = ROOT_BITS'(1) << HALF_BITS;
                    n_z0sq  = SQ_BITS'(1) << (2 * HALF_BITS);
                end
                OP_DEC_Z0: begin
                    // (z-1)^2 = z^2 - (2z - 1)
                    n_z0   = r_z0 - ROOT_BITS'(1);
                    n_z0sq = r_z0sq - ((SQ_BITS'(r_z0) << 1) - SQ_BITS'(1));
                end
                OP_LOAD_Y0: begin
                    n_y   = '0;
                    n_ysq = '0;
                    n_z   = r_z0;
                    n_zsq = r_z0sq;
                end
                OP_LOAD_R: begin
                    n_r = r_rest - r_ysq;
                end
                OP_DEC_Z: begin
                    n_z   = r_z - ROOT_BITS'(1);
                    n_zsq = r_zsq - ((SQ_BITS'(r_z) << 1) - SQ_BITS'(1));
                end
                OP_ACCUM: begin
                    if (hit) begin
                        n_total = acc_sum[COUNT_BITS] ? COUNT_MAX : acc_sum[COUNT_BITS-1:0];
                    end
                end
                OP_INC_Y: begin
                    // (y+1)^2 = y^2 + 2y + 1
                    n_y   = r_y + ROOT_BITS'(1);
                    n_ysq = r_ysq + (SQ_BITS'(r_y) << 1) + SQ_BITS'(1);
                end
                OP_INC_X: begin
                    n_x    = r_x + ROOT_BITS'(1);
                    n_xsq  = r_xsq + (SQ_BITS'(r_x) << 1) + SQ_BITS'(1);
                    n_rest = r_rest - ((SQ_BITS'(r_x) << 1) + SQ_BITS'(1));
                end
                OP_SET_ONE: begin
                    n_total = COUNT_BITS'(1);
                end
                OP_FINISH: begin
                    n_count = r_total;
                    n_done  = 1'b1;
                    n_busy  = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    // State and datapath registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_pc   <= S_START;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_pc   <= n_pc;
        end
        r_m     <= n_m;
        r_x     <= n_x;
        r_y     <= n_y;
        r_z     <= n_z;
        r_z0    <= n_z0;
        r_xsq   <= n_xsq;
        r_ysq   <= n_ysq;
        r_zsq   <= n_zsq;
        r_z0sq  <= n_z0sq;
        r_rest  <= n_rest;
        r_r     <= n_r;
        r_total <= n_total;
        r_count <= n_count;
    end

    // The result strobe lasts exactly one cycle.
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held longer than one cycle");

    // An accepted request makes the block busy on the next cycle.
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    // The incrementally kept x^2 matches x while a row is being walked.
    a_xsq_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_pc == S_YC) |-> (r_xsq == SQ_BITS'(SQ_BITS'(r_x) * SQ_BITS'(r_x))))
        else $error("x square out of step with x");

    // When the hit test runs, z has walked down to the floor root of the rest.
    a_z_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_pc == S_ACC) |-> (r_zsq <= r_r))
        else $error("z pointer above the square root of the rest");

    // A result appears only as the block leaves the busy state.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (!busy && $past(busy)))
        else $error("result strobe without a request in flight");

endmodule

// ----- tb/sum_of_three_squares_count_tb.sv -----
// Self-checking testbench for the lattice point counter: directed and random distances.
`timescale 1ns / 1ps

module sum_of_three_squares_count_tb
    import s3sq_pkg::*;
();

    // Run control. A 16-bit distance takes long to count, so most random requests
    // stay small and only a few directed ones are large.
    localparam int unsigned CYCLE_LIMIT = 12_000_000;
    localparam int          DRAIN_CYCLES = 20;

    // Variant counts of one ordered triple x >= y >= z >= 0.
    localparam int ONE_AXIS     = 6;
    localparam int TWO_EQUAL_XY = 12;
    localparam int TWO_UNEQUAL  = 24;
    localparam int ALL_EQUAL    = 8;
    localparam int ONE_PAIR     = 24;
    localparam int ALL_DISTINCT = 48;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [DIST_BITS-1:0]  i_squared_distance = '0;
    logic                  o_done;
    logic [COUNT_BITS-1:0] o_point_count;

    // Counts still owed by the block, oldest first.
    logic [COUNT_BITS-1:0] pending_counts[$];

    int unsigned cycle_count = 0;
    int          error_count = 0;
    int          requests_sent = 0;
    int          counts_checked = 0;
    int          largest_distance = 0;

    sum_of_three_squares_count dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_squared_distance (i_squared_distance),
        .o_done             (o_done),
        .o_point_count      (o_point_count)
    );

    // 100 MHz clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Floor of the square root, one result bit per pass.
    function automatic longint unsigned floor_root(input longint unsigned v);
        longint unsigned root;
        longint unsigned probe;
        begin
            root = 0;
            probe = 64'd1 << 62;
            while (probe > v)
                probe = probe >> 2;
            while (probe != 0) begin
                if (v >= root + probe) begin
                    v = v - (root + probe);
                    root = (root >> 1) + probe;
                end else begin
                    root = root >> 1;
                end
                probe = probe >> 2;
            end
            return root;
        end
    endfunction

    // Number of signed, reordered copies of the triple x >= y >= z >= 0.
    function automatic int triple_copies(input longint unsigned x, input longint unsigned y,
                                         input longint unsigned z);
        begin
            if (y == 0)
                return ONE_AXIS;
            if (z == 0)
                return (x == y) ? TWO_EQUAL_XY : TWO_UNEQUAL;
            if (x == y && y == z)
                return ALL_EQUAL;
            if (x == y || y == z)
                return ONE_PAIR;
            return ALL_DISTINCT;
        end
    endfunction

    // Expected number of lattice points at squared distance m, saturating.
    function automatic logic [COUNT_BITS-1:0] lattice_points(input logic [DIST_BITS-1:0] m);
        longint unsigned m_val;
        longint unsigned total;
        longint unsigned x_top;
        longint unsigned rest;
        longint unsigned r;
        longint unsigned z;
        begin
            m_val = longint'(m);
            total = 0;
            if (m_val == 0)
                return COUNT_BITS'(1);
            x_top = floor_root(m_val);
            for (longint unsigned x = 0; x <= x_top; x++) begin
                rest = m_val - x * x;
                for (longint unsigned y = 0; y <= x && y * y <= rest; y++) begin
                    r = rest - y * y;
                    z = floor_root(r);
                    if (z * z == r && z <= y)
                        total += triple_copies(x, y, z);
                end
            end
            if (total > longint'(COUNT_MAX))
                total = longint'(COUNT_MAX);
            return COUNT_BITS'(total);
        end
    endfunction

    // Send one request after an optional idle gap. The request is taken at the
    // first edge with start high and busy low; start is left high on return so
    // that a back-to-back request needs no extra edge.
    task automatic send_distance(input logic [DIST_BITS-1:0] m, input int gap);
        logic [COUNT_BITS-1:0] expected;
        begin
            expected = lattice_points(m);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            start <= 1'b1;
            i_squared_distance <= m;
            @(posedge i_clk);
            while (busy)
                @(posedge i_clk);
            pending_counts = {pending_counts, expected};
            requests_sent++;
            if (int'(m) > largest_distance)
                largest_distance = int'(m);
        end
    endtask

    // The origin alone, distance one, and bit patterns (all ones, alternating bits).
    task automatic test_zero_and_extremes();
        begin
            send_distance('0, 0);
            send_distance(DIST_BITS'(1), 0);
            send_distance({DIST_BITS{1'b1}}, 0);
            send_distance(DIST_BITS'(16'h5555), 2);
            send_distance(DIST_BITS'(16'h00aa), 0);
        end
    endtask

    // One distance for each kind of triple: on an axis, two equal, two unequal,
    // all equal, one pair, all distinct, and several distances that mix kinds.
    task automatic test_triple_kinds();
        begin
            send_distance(DIST_BITS'(4), 0);
            send_distance(DIST_BITS'(2), 1);
            send_distance(DIST_BITS'(5), 0);
            send_distance(DIST_BITS'(3), 0);
            send_distance(DIST_BITS'(6), 3);
            send_distance(DIST_BITS'(14), 0);
            send_distance(DIST_BITS'(9), 0);
            send_distance(DIST_BITS'(27), 0);
            send_distance(DIST_BITS'(50), 1);
            send_distance(DIST_BITS'(129), 0);
        end
    endtask

    // Distances of the form 4^a(8b+7) have no representation at all.
    task automatic test_no_representation();
        begin
            send_distance(DIST_BITS'(7), 0);
            send_distance(DIST_BITS'(15), 0);
            send_distance(DIST_BITS'(28), 2);
            send_distance(DIST_BITS'(60), 0);
            send_distance(DIST_BITS'(112), 0);
        end
    endtask

    // Random distances, mostly small so the run stays short, with the sender
    // pausing before a request in idle_pct of a hundred.
    task automatic test_random_distances(input int num_requests, input int idle_pct);
        logic [DIST_BITS-1:0] m;
        int                   gap;
        begin
            for (int i = 0; i < num_requests; i++) begin
                if ($urandom_range(0, 99) < 85)
                    m = DIST_BITS'($urandom_range(0, 1023));
                else
                    m = DIST_BITS'($urandom_range(1024, 8191));
                gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 6) : 0;
                send_distance(m, gap);
            end
        end
    endtask

    // Compare each count with the oldest one owed.
    always @(posedge i_clk) begin
        logic [COUNT_BITS-1:0] expected;
        if (i_rst_n && o_done) begin
            if (pending_counts.size() == 0) begin
                $error("unexpected result: point_count %0d with no request pending",
                       o_point_count);
                error_count++;
            end else begin
                expected = pending_counts.pop_front();
                counts_checked++;
                if (o_point_count !== expected) begin
                    $error("point_count mismatch: expected %0d, actual %0d",
                           expected, o_point_count);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d counts still owed",
                     cycle_count, pending_counts.size());
            $display("sum_of_three_squares_count_tb: FAIL");
            $finish;
        end
    end

    // Test sequence.
    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_zero_and_extremes();
        test_triple_kinds();
        test_no_representation();
        test_random_distances(30, 0);
        test_random_distances(30, 67);
        test_random_distances(30, 19);
        test_random_distances(30, 0);

        // Drain the last count, then allow a few quiet cycles.
        start <= 1'b0;
        while (pending_counts.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d distances (largest %0d), checked %0d counts in %0d cycles.",
                 requests_sent, largest_distance, counts_checked, cycle_count);
        $display("Covered the origin, every triple kind, empty shells and idle patterns.");
        if (error_count == 0) begin
            $display("sum_of_three_squares_count_tb: PASS");
        end else begin
            $display("sum_of_three_squares_count_tb: FAIL");
        end
        $finish;
    end

endmodule
